/* hdl/triangle_rasterizer_framebuffer_defines.svh */
// ----------------------------------------------------------------------------
// Triangle rasterizer framebuffer assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_RASTERIZER_FRAMEBUFFER_DEFINES_SVH
`define TRIANGLE_RASTERIZER_FRAMEBUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held
`define TRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is held
`define TRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/trf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle rasterizer framebuffer package
// Field widths, request codes, controller states and control structs.
// ----------------------------------------------------------------------------
package trf_pkg;

    localparam int COORD_W = 14;
    localparam int COLOR_W = 24;
    localparam int REQ_W   = 2;
    localparam int RES_W   = 9;
    localparam int RD_W    = 8;
    localparam int MUL_CW  = 3;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_FILL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRI  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Six products (two per edge), then a drain step for the product register
    localparam logic [MUL_CW-1:0] MUL_DRAIN = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BBOX,
        ST_CLAMP,
        ST_MUL,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              clear_step;
        logic              bbox;
        logic              clamp;
        logic              mul_en;
        logic [MUL_CW-1:0] mul_idx;
        logic              scan_init;
        logic              scan_step;
        logic              rd_en;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic fill;
        logic box_empty;
        logic scan_last;
    } ctrl_stat_t;

endpackage

/* hdl/trf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle rasterizer controller
// Sequences clearing, setup, scan, read-back and result handoff.
// ----------------------------------------------------------------------------
`include "triangle_rasterizer_framebuffer_defines.svh"

module trf_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [trf_pkg::REQ_W-1:0] in_req,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  trf_pkg::ctrl_stat_t      stat,
    output trf_pkg::ctrl_cmd_t       cmd
);

    trf_pkg::state_t                 state_reg, state_next;
    logic [trf_pkg::MUL_CW-1:0]      mul_cnt_reg, mul_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            accept;

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            trf_pkg::ST_CLEAR: begin
                if (stat.clear_last) state_next = trf_pkg::ST_IDLE;
            end
            trf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_req)
                        trf_pkg::REQ_FILL: state_next = trf_pkg::ST_BBOX;
                        trf_pkg::REQ_TRI:  state_next = trf_pkg::ST_BBOX;
                        trf_pkg::REQ_READ: state_next = trf_pkg::ST_READ;
                        default:           state_next = trf_pkg::ST_DONE;
                    endcase
                end
            end
            trf_pkg::ST_BBOX:  state_next = trf_pkg::ST_CLAMP;
            trf_pkg::ST_CLAMP: begin
                state_next = stat.fill ? trf_pkg::ST_SCAN_INIT : trf_pkg::ST_MUL;
            end
            trf_pkg::ST_MUL: begin
                if (mul_cnt_reg == trf_pkg::MUL_DRAIN) begin
                    state_next = stat.box_empty ? trf_pkg::ST_DONE : trf_pkg::ST_SCAN_INIT;
                end
            end
            trf_pkg::ST_SCAN_INIT: state_next = trf_pkg::ST_SCAN;
            trf_pkg::ST_SCAN: begin
                if (stat.scan_last) state_next = trf_pkg::ST_DONE;
            end
            trf_pkg::ST_READ: state_next = trf_pkg::ST_DONE;
            trf_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) state_next = trf_pkg::ST_IDLE;
            end
            default: state_next = trf_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        cmd.mul_idx  = mul_cnt_reg;
        case (state_reg)
            trf_pkg::ST_CLEAR:     cmd.clear_step = 1'b1;
            trf_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            trf_pkg::ST_BBOX:      cmd.bbox = 1'b1;
            trf_pkg::ST_CLAMP:     cmd.clamp = 1'b1;
            trf_pkg::ST_MUL:       cmd.mul_en = (mul_cnt_reg != trf_pkg::MUL_DRAIN);
            trf_pkg::ST_SCAN_INIT: cmd.scan_init = 1'b1;
            trf_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
            trf_pkg::ST_READ:      cmd.rd_en = 1'b1;
            trf_pkg::ST_DONE:      cmd.out_load = !out_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Counter and result-valid next values
    always_comb begin
        mul_cnt_next = '0;
        if (state_reg == trf_pkg::ST_MUL) mul_cnt_next = mul_cnt_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= trf_pkg::ST_CLEAR;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TRF_ASSERT_IMP(a_out_free, aclk, aresetn, cmd.out_load, !out_valid_reg || m_tready)
    `TRF_ASSERT_NXT(a_accept_leaves, aclk, aresetn, accept, state_reg != trf_pkg::ST_IDLE)
    `TRF_ASSERT_NXT(a_scan_holds, aclk, aresetn, cmd.scan_step && !stat.scan_last, state_reg == trf_pkg::ST_SCAN)

endmodule

/* hdl/trf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle rasterizer datapath
// Frame store, bounding box, edge setup multiplier and incremental edge scan.
// ----------------------------------------------------------------------------
`include "triangle_rasterizer_framebuffer_defines.svh"

module trf_datapath #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 4
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  trf_pkg::ctrl_cmd_t                      cmd,
    output trf_pkg::ctrl_stat_t                     stat,
    input  logic                                    cfg_wr_en,
    input  logic [trf_pkg::RES_W-1:0]               cfg_wr_data,
    input  logic [trf_pkg::REQ_W-1:0]               in_req,
    input  logic [5:0][trf_pkg::COORD_W-1:0]        in_vertex,
    input  logic [trf_pkg::COLOR_W-1:0]             in_color,
    input  logic [trf_pkg::RD_W-1:0]                in_read_x,
    input  logic [trf_pkg::RD_W-1:0]                in_read_y,
    output logic [trf_pkg::COLOR_W-1:0]             out_pixel,
    output logic                                    out_done
);

    localparam int XW    = $clog2(MAX_SIDE);
    localparam int BW    = XW + 1;
    localparam int AW    = 2 * XW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = trf_pkg::COORD_W + 1;
    localparam int SH    = FRACTION_BITS + 1;
    localparam int ONE   = 1 << SH;
    localparam int PXW   = XW + 3 + FRACTION_BITS;
    localparam int P_W   = ((PXW > CW) ? PXW : CW) + 1;
    localparam int D_W   = CW + 1;
    localparam int M_W   = P_W + D_W;
    localparam int E_W   = M_W + 1;
    localparam int LW    = trf_pkg::RES_W + SH;
    localparam int CLW   = ((CW > LW) ? CW : LW) + 1;
    localparam int RES_RST = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    logic [trf_pkg::RES_W-1:0]   res_reg, res_next;
    logic [trf_pkg::REQ_W-1:0]   req_reg;
    logic [trf_pkg::COORD_W-1:0] vtx_reg [6];
    logic [trf_pkg::COLOR_W-1:0] color_reg;
    logic [trf_pkg::RD_W-1:0]    rx_reg, ry_reg;
    logic signed [CW-1:0]        dv [6];
    logic signed [CW-1:0]        minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic [BW-1:0]               x0_reg, x1_reg, y0_reg, y1_reg;
    logic [BW-1:0]               x_reg, y_reg;
    logic signed [D_W-1:0]       edge_a [3];
    logic signed [D_W-1:0]       edge_b [3];
    logic signed [E_W-1:0]       sx [3];
    logic signed [E_W-1:0]       sy [3];
    logic signed [P_W-1:0]       px0, py0, op_a;
    logic signed [D_W-1:0]       op_b;
    logic [1:0]                  k_sel, pk;
    logic signed [M_W-1:0]       prod_reg;
    logic [trf_pkg::MUL_CW-1:0]  prod_idx_reg;
    logic                        prod_vld_reg;
    logic signed [E_W-1:0]       e_acc_reg [3];
    logic signed [E_W-1:0]       e_row_reg [3];
    logic signed [E_W-1:0]       e_cur_reg [3];
    logic [CLW-1:0]              lim;
    logic [CLW-1:0]              cminx, cmaxx, cminy, cmaxy;
    logic [AW-1:0]               clr_reg;
    logic [trf_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [trf_pkg::COLOR_W-1:0] rd_data_reg;
    logic                        mem_we, pix_hit, row_end, in_range;
    logic [AW-1:0]               mem_waddr, rd_addr;
    logic [trf_pkg::COLOR_W-1:0] mem_wdata;

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [CLW-1:0] clampv(input logic signed [CW-1:0] v,
                                              input logic [CLW-1:0] hi);
        logic signed [CLW-1:0] vs;
        vs = CLW'(v);
        if (vs < 0) return '0;
        if (vs > $signed(hi)) return hi;
        return vs;
    endfunction

    // Clamp written resolution to 1..MAX_SIDE
    always_comb begin
        res_next = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            res_next = trf_pkg::RES_W'(1);
        end else if (int'(cfg_wr_data) > MAX_SIDE) begin
            res_next = trf_pkg::RES_W'(MAX_SIDE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= trf_pkg::RES_W'(RES_RST);
        end else if (cfg_wr_en) begin
            res_reg <= res_next;
        end
    end

    // Capture the request transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= in_req;
            color_reg <= in_color;
            rx_reg    <= in_read_x;
            ry_reg    <= in_read_y;
            for (int i = 0; i < 6; i++) vtx_reg[i] <= in_vertex[i];
        end
    end

    // Doubled vertices and per-edge deltas
    always_comb begin
        for (int i = 0; i < 6; i++) dv[i] = $signed({vtx_reg[i], 1'b0});
    end

    for (genvar k = 0; k < 3; k++) begin : g_edge
        localparam int KN = (k + 1) % 3;
        assign edge_a[k] = D_W'(dv[2*KN+1]) - D_W'(dv[2*k+1]);
        assign edge_b[k] = D_W'(dv[2*KN]) - D_W'(dv[2*k]);
        assign sx[k]     = E_W'(edge_a[k]) <<< SH;
        assign sy[k]     = E_W'(edge_b[k]) <<< SH;
    end

    // Bounding box, then clamp and round to pixel bounds
    assign lim   = CLW'(res_reg) << SH;
    assign cminx = clampv(minx_reg, lim);
    assign cmaxx = clampv(maxx_reg, lim);
    assign cminy = clampv(miny_reg, lim);
    assign cmaxy = clampv(maxy_reg, lim);

    always_ff @(posedge aclk) begin
        if (cmd.bbox) begin
            minx_reg <= min3(dv[0], dv[2], dv[4]);
            maxx_reg <= max3(dv[0], dv[2], dv[4]);
            miny_reg <= min3(dv[1], dv[3], dv[5]);
            maxy_reg <= max3(dv[1], dv[3], dv[5]);
        end
        if (cmd.clamp) begin
            if (req_reg == trf_pkg::REQ_FILL) begin
                x0_reg <= '0;
                y0_reg <= '0;
                x1_reg <= BW'(res_reg);
                y1_reg <= BW'(res_reg);
            end else begin
                x0_reg <= BW'(cminx >> SH);
                y0_reg <= BW'(cminy >> SH);
                x1_reg <= BW'((cmaxx + CLW'(ONE - 1)) >> SH);
                y1_reg <= BW'((cmaxy + CLW'(ONE - 1)) >> SH);
            end
        end
    end

    // Edge values at the first pixel center through one shared multiplier
    assign k_sel = cmd.mul_idx[2:1];
    assign pk    = prod_idx_reg[2:1];
    assign px0   = $signed(P_W'({x0_reg, 1'b1}) << FRACTION_BITS);
    assign py0   = $signed(P_W'({y0_reg, 1'b1}) << FRACTION_BITS);

    always_comb begin
        if (cmd.mul_idx[0]) begin
            op_a = py0 - P_W'(dv[2*k_sel+1]);
            op_b = edge_b[k_sel];
        end else begin
            op_a = px0 - P_W'(dv[2*k_sel]);
            op_b = edge_a[k_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg     <= op_a * op_b;
            prod_idx_reg <= cmd.mul_idx;
        end
        if (prod_vld_reg) begin
            if (prod_idx_reg[0]) begin
                e_acc_reg[pk] <= e_acc_reg[pk] - E_W'(prod_reg);
            end else begin
                e_acc_reg[pk] <= E_W'(prod_reg);
            end
        end
    end

    // Scan the box one pixel a cycle, stepping the edge values
    assign row_end = (BW'(x_reg + 1'b1) == x1_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            x_reg <= x0_reg;
            y_reg <= y0_reg;
            for (int k = 0; k < 3; k++) begin
                e_row_reg[k] <= e_acc_reg[k];
                e_cur_reg[k] <= e_acc_reg[k];
            end
        end else if (cmd.scan_step) begin
            if (row_end) begin
                x_reg <= x0_reg;
                y_reg <= BW'(y_reg + 1'b1);
                for (int k = 0; k < 3; k++) begin
                    e_row_reg[k] <= e_row_reg[k] - sy[k];
                    e_cur_reg[k] <= e_row_reg[k] - sy[k];
                end
            end else begin
                x_reg <= BW'(x_reg + 1'b1);
                for (int k = 0; k < 3; k++) e_cur_reg[k] <= e_cur_reg[k] + sx[k];
            end
        end
    end

    assign pix_hit = !e_cur_reg[0][E_W-1] && !e_cur_reg[1][E_W-1] && !e_cur_reg[2][E_W-1];

    // Clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Frame store write and read ports
    always_comb begin
        if (cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = trf_pkg::WHITE;
        end else begin
            mem_we    = cmd.scan_step && (stat.fill || pix_hit);
            mem_waddr = {y_reg[XW-1:0], x_reg[XW-1:0]};
            mem_wdata = color_reg;
        end
    end

    assign rd_addr = {XW'(ry_reg), XW'(rx_reg)};

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Result register
    assign in_range = ({1'b0, rx_reg} < res_reg) && ({1'b0, ry_reg} < res_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (req_reg)
                trf_pkg::REQ_FILL: begin
                    out_pixel <= '0;
                    out_done  <= 1'b1;
                end
                trf_pkg::REQ_TRI: begin
                    out_pixel <= '0;
                    out_done  <= 1'b1;
                end
                trf_pkg::REQ_READ: begin
                    out_pixel <= in_range ? rd_data_reg : '0;
                    out_done  <= 1'b1;
                end
                default: begin
                    out_pixel <= '0;
                    out_done  <= 1'b0;
                end
            endcase
        end
    end

    assign stat.clear_last = &clr_reg;
    assign stat.fill       = (req_reg == trf_pkg::REQ_FILL);
    assign stat.box_empty  = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
    assign stat.scan_last  = row_end && (BW'(y_reg + 1'b1) == y1_reg);

    `TRF_ASSERT_IMP(a_scan_in_box, aclk, aresetn, cmd.scan_step, (x_reg < x1_reg) && (y_reg < y1_reg))
    `TRF_ASSERT_IMP(a_scan_in_frame, aclk, aresetn, cmd.scan_step, int'(x1_reg) <= MAX_SIDE)
    `TRF_ASSERT_NXT(a_clear_wraps, aclk, aresetn, cmd.clear_step && stat.clear_last, clr_reg == '0)

endmodule

/* hdl/triangle_rasterizer_framebuffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle rasterizer framebuffer
// Square RGB frame store with fill, edge-function triangle draw and read-back.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes white to every
// frame store entry, one per cycle, and takes no request until it ends;
// resolution writes are taken at any time. Requests are handled one at a
// time. A fill skips the edge setup and scans the whole frame; a triangle
// runs bounding box, clamp, edge setup and scan, and skips the scan when
// its box is empty; a read uses the registered read port. Every result
// passes through the output register. Scan time is set by the frame store's
// single write port, which paints one pixel of the bounding box per cycle.
// ----------------------------------------------------------------------------
module triangle_rasterizer_framebuffer #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [8:0]   cfg_wr_data,   // resolution
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // paint_color, read_x, read_y, zero pad
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,       // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,       // pixel_value
    output logic [0:0]   m_tuser        // request_done
);

    localparam int VW   = trf_pkg::COORD_W;
    localparam int CB   = 6 * VW;
    localparam int RXB  = CB + trf_pkg::COLOR_W;
    localparam int RYB  = RXB + trf_pkg::RD_W;

    trf_pkg::ctrl_cmd_t                   cmd;
    trf_pkg::ctrl_stat_t                  stat;
    logic [5:0][trf_pkg::COORD_W-1:0]     vertex;

    // Unpack the vertex fields
    assign vertex = s_tdata[CB-1:0];

    trf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_req   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trf_datapath #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_req      (s_tuser),
        .in_vertex   (vertex),
        .in_color    (s_tdata[RXB-1:CB]),
        .in_read_x   (s_tdata[RYB-1:RXB]),
        .in_read_y   (s_tdata[RYB+trf_pkg::RD_W-1:RYB]),
        .out_pixel   (m_tdata),
        .out_done    (m_tuser[0])
    );

endmodule
